// ===== src/dhht_pkg.sv =====
// Package for the double hashing hash table.
// Holds command, result and slot state codes. No dependencies.
package dhht_pkg;
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        RES_INSERTED  = 3'd0,
        RES_FULL      = 3'd1,
        RES_FOUND     = 3'd2,
        RES_NOT_FOUND = 3'd3,
        RES_DELETED   = 3'd4,
        RES_DEL_MISS  = 3'd5
    } res_t;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_USED  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    localparam int KEY_W = 31;
    localparam int CNT_W = 32;
endpackage

// ===== src/double_hashing_hash_table.sv =====
// After reset a clearing pass marks every slot empty before the first word is taken.
// Per word: the word is taken in S_IDLE, the key is reduced in S_DIV, each probe
// passes through S_READ and S_EVAL, and the result is held in S_OUT until out_ready.
// Throughput: one word at a time; probes are bounded by the table size, one slot read
// per probe from the status and key memories. Reset clears control state, table size
// returns to 1024 and the collision total to zero.
module double_hashing_hash_table #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [10:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               command,
    input  logic [30:0]              key,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               status,
    output logic [9:0]               slot_index,
    output logic [31:0]              collision_count
);
    import dhht_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int MW = $clog2(MAX_SLOTS + 1);
    localparam int DW = (MW > 11) ? MW : 11;
    localparam int KC = $clog2(KEY_W + 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_READ  = 6'b001000,
        S_EVAL  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]        stat_mem [MAX_SLOTS];
    logic [KEY_W-1:0]  key_mem  [MAX_SLOTS];
    logic [1:0]        stat_rd;
    logic [KEY_W-1:0]  key_rd;

    logic [10:0]       tsize_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [AW-1:0]     clr_reg;
    logic [1:0]        cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [MW-1:0]     m_reg;
    logic [MW-1:0]     r1_reg, r2_reg;   // remainders mod m and mod m-1
    logic [KC-1:0]     bit_reg;
    logic [MW-1:0]     pos_reg, step_reg;
    logic [MW-1:0]     probe_reg;
    logic [2:0]        res_reg;
    logic [9:0]        where_reg;

    logic [DW-1:0]     m_eff;
    logic [MW:0]       sh1, sh2;
    logic [MW-1:0]     mm1;
    logic [MW:0]       pos_sum;
    logic              hit_free, hit_key, last_probe;
    logic [CNT_W:0]    add_sum;
    logic [MW-1:0]     add_n;
    logic              wr_en;
    logic [1:0]        wr_stat;

    always_comb
    begin
        m_eff = DW'(tsize_reg);
        if (m_eff < DW'(2))
            m_eff = DW'(2);
        if (m_eff > DW'(MAX_SLOTS))
            m_eff = DW'(MAX_SLOTS);
    end

    assign mm1 = m_reg - MW'(1);
    // restoring remainder, one key bit a cycle, for both moduli
    assign sh1 = {r1_reg, key_reg[KEY_W - 1 - 32'(bit_reg)]};
    assign sh2 = {r2_reg, key_reg[KEY_W - 1 - 32'(bit_reg)]};
    assign pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};

    assign hit_free   = (stat_rd != ST_USED);
    assign hit_key    = (stat_rd == ST_USED) && (key_rd == key_reg);
    assign last_probe = (probe_reg == mm1);

    always_ff @(posedge clk)
    begin
        stat_rd <= stat_mem[pos_reg[AW-1:0]];
        key_rd  <= key_mem[pos_reg[AW-1:0]];
        if (state_reg == S_CLEAR)
            stat_mem[clr_reg] <= ST_EMPTY;
        else if (wr_en)
            stat_mem[pos_reg[AW-1:0]] <= wr_stat;
        if (wr_en && wr_stat == ST_USED)
            key_mem[pos_reg[AW-1:0]] <= key_reg;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_stat = ST_USED;
        add_n   = '0;
        if (state_reg == S_EVAL)
        begin
            unique case (cmd_reg)
                CMD_INSERT:
                begin
                    wr_en = hit_free;
                    // count retries only once the insert ends
                    add_n = hit_free ? probe_reg : (last_probe ? mm1 : '0);
                end
                CMD_DELETE:
                begin
                    wr_en   = hit_key;
                    wr_stat = ST_TOMB;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    assign add_sum = {1'b0, total_reg} + (CNT_W + 1)'(add_n);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == AW'(MAX_SLOTS - 1)) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_DIV;
            S_DIV:   if (bit_reg == KC'(KEY_W - 1)) state_next = S_READ;
            S_READ:  state_next = S_EVAL;
            S_EVAL:
            begin
                priority if (cmd_reg == CMD_NONE) state_next = S_OUT;
                else if (cmd_reg == CMD_INSERT && hit_free) state_next = S_OUT;
                else if (cmd_reg != CMD_INSERT && (hit_key || stat_rd == ST_EMPTY))
                    state_next = S_OUT;
                else if (last_probe) state_next = S_OUT;
                else state_next = S_READ;
            end
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            tsize_reg <= 11'd1024;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (cfg_we)
                tsize_reg <= cfg_data;
            if (state_reg == S_EVAL && add_n != '0)
                total_reg <= add_sum[CNT_W] ? {CNT_W{1'b1}} : add_sum[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg   <= command;
                key_reg   <= key;
                m_reg     <= MW'(m_eff);
                r1_reg    <= '0;
                r2_reg    <= '0;
                bit_reg   <= '0;
                probe_reg <= '0;
            end
            S_DIV:
            begin
                bit_reg <= bit_reg + KC'(1);
                r1_reg  <= (sh1 >= {1'b0, m_reg}) ? MW'(sh1 - {1'b0, m_reg}) : MW'(sh1);
                r2_reg  <= (sh2 >= {1'b0, mm1}) ? MW'(sh2 - {1'b0, mm1}) : MW'(sh2);
                if (bit_reg == KC'(KEY_W - 1))
                begin
                    pos_reg  <= (sh1 >= {1'b0, m_reg}) ? MW'(sh1 - {1'b0, m_reg}) : MW'(sh1);
                    step_reg <= ((sh2 >= {1'b0, mm1}) ? MW'(sh2 - {1'b0, mm1}) : MW'(sh2))
                                + MW'(1);
                end
            end
            S_EVAL:
            begin
                // default result, overwritten by the command's own result
                res_reg   <= RES_NOT_FOUND;
                where_reg <= '0;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        res_reg   <= hit_free ? RES_INSERTED : RES_FULL;
                        where_reg <= hit_free ? 10'(pos_reg) : '0;
                    end
                    CMD_SEARCH:
                    begin
                        res_reg   <= hit_key ? RES_FOUND : RES_NOT_FOUND;
                        where_reg <= hit_key ? 10'(pos_reg) : '0;
                    end
                    CMD_DELETE:
                    begin
                        res_reg   <= hit_key ? RES_DELETED : RES_DEL_MISS;
                        where_reg <= hit_key ? 10'(pos_reg) : '0;
                    end
                    default:
                    begin
                        res_reg <= RES_NOT_FOUND;
                    end
                endcase
                // advance to the next probe slot
                probe_reg <= probe_reg + MW'(1);
                pos_reg   <= (pos_sum >= {1'b0, m_reg}) ? MW'(pos_sum - {1'b0, m_reg})
                                                        : MW'(pos_sum);
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = (state_reg == S_OUT);
    assign status          = res_reg;
    assign slot_index      = where_reg;
    assign collision_count = total_reg;
endmodule

// ===== src/dhht_checker.sv =====
// Port-level checks for the double hashing hash table.
// Depends on dhht_pkg; bound to double_hashing_hash_table.
module dhht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [9:0]  slot_index,
    input logic [31:0] collision_count
);
    import dhht_pkg::*;

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready while a word is pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index))
        else $error("result dropped");

    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == RES_FULL || status == RES_NOT_FOUND
                      || status == RES_DEL_MISS) |-> slot_index == 10'd0)
        else $error("miss with slot");

    a_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) |-> collision_count >= $past(collision_count))
        else $error("total went down");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'd5)
        else $error("bad status");
endmodule

bind double_hashing_hash_table dhht_checker u_dhht_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .slot_index(slot_index), .collision_count(collision_count)
);
